/* hw/rtl/button_debounce_autorepeat_defines.svh */
// ---------------------------------------------------------------------------
// Button debounce / auto-repeat assertion macros
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bda_pkg.sv */
// ---------------------------------------------------------------------------
// bda_pkg
// Types and constants shared by the debounce / auto-repeat block and its
// port checker.
// ---------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    // Fixed field widths
    localparam int IDX_W   = 3;
    localparam int CMD_W   = 2;
    localparam int MASK_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 64;
    localparam int CFGA_W  = 3;
    localparam int MS_W    = 16;

    // Parameter defaults
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int EVENT_BITS_DEF  = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP    = 2'd2;

    // Register indexes
    localparam logic [CFGA_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFGA_W-1:0] REG_DELAY    = 3'd1;
    localparam logic [CFGA_W-1:0] REG_INTERVAL = 3'd2;
    localparam logic [CFGA_W-1:0] REG_ENABLE   = 3'd3;
    localparam logic [CFGA_W-1:0] REG_REPEAT   = 3'd4;
    localparam logic [CFGA_W-1:0] REG_EVENTS   = 3'd5;

    // Register reset values
    localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd20;
    localparam logic [MS_W-1:0]   DELAY_RST    = 16'd500;
    localparam logic [MS_W-1:0]   INTERVAL_RST = 16'd0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RAW,
        ST_DEB,
        ST_ARM,
        ST_RPT,
        ST_DIV,
        ST_ADV1,
        ST_ADV2,
        ST_FIRE,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/button_debounce_autorepeat.sv */
// ---------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces a mask of button levels against a millisecond timestamp and
// emits bound event codes on press and on auto-repeat.
// ---------------------------------------------------------------------------
// Usage: one input beat carries a command, a level mask and a wrapping ms
// timestamp. After the accepting edge, init keeps in_stall high in ST_INIT;
// map-changed and ignored beats leave in_stall low. An update walks the
// buttons one at a time through a single shared 32-bit add/subtract unit:
// ST_RAW and ST_DEB per button, then ST_ARM and ST_FIRE for an enabled
// press (ST_ARM alone for a disabled one), and ST_RPT, ST_DIV, ST_ADV1,
// ST_ADV2 and ST_FIRE for a repeat, which runs a 31-step bit-serial
// remainder on the same unit to skip missed intervals. ST_FLUSH ends the
// beat; ST_FIRE and ST_FLUSH can wait while the output is stalled. Events
// come out in ascending button order, the final one of a beat marked by
// last. in_stall is high while a beat is being worked on; the next beat can
// be taken while the final event still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int EVENT_BITS  = EVENT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_write,
    input  wire logic [CFGA_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [MASK_W-1:0]     level_mask,
    input  wire logic [TIME_W-1:0]     time_ms,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IDX_W-1:0]           button_index,
    output logic [EVENT_BITS-1:0]      event_code,
    output logic                       last
);

    localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // configuration registers
    logic [MS_W-1:0]   debounce_reg;
    logic [MS_W-1:0]   delay_reg;
    logic [MS_W-1:0]   interval_reg;
    logic [MASK_W-1:0] enable_reg;
    logic [MASK_W-1:0] repeat_reg;
    logic [CFG_W-1:0]  events_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [BTN_W-1:0] btn_reg, btn_next;
    logic             ready_reg, ready_next;

    // latched input beat
    logic [NUM_BUTTONS-1:0] level_reg;
    logic [TIME_W-1:0]      now_reg;

    // per-button state
    logic [NUM_BUTTONS-1:0] raw_reg;
    logic [NUM_BUTTONS-1:0] stable_reg;
    logic [NUM_BUTTONS-1:0] blocked_reg;
    logic [TIME_W-1:0]      ct_reg  [NUM_BUTTONS];
    logic [TIME_W-1:0]      nrt_reg [NUM_BUTTONS];

    // shared unit scratch
    logic [TIME_W-1:0] tmp_reg;
    logic [TIME_W-2:0] dq_reg;
    logic [MS_W-1:0]   rem_reg;
    logic [4:0]        div_cnt_reg;

    // pending and output registers
    logic                  pend_valid_reg, pend_valid_next;
    logic [BTN_W-1:0]      pend_idx_reg;
    logic [EVENT_BITS-1:0] pend_code_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [BTN_W-1:0]      out_idx_reg;
    logic [EVENT_BITS-1:0] out_code_reg;
    logic                  out_last_reg;

    // control strobes
    logic in_accept;
    logic out_free;
    logic out_load;
    logic out_load_last;
    logic pend_load;
    logic go_next;
    logic deb_hit;

    // current button view
    logic              lvl, cur_raw, cur_stable, cur_blocked, cur_en, cur_rp;
    logic [TIME_W-1:0] ct_new;
    logic [EVENT_BITS-1:0] cur_code;
    logic [MS_W:0]     shifted;

    // shared adder
    logic [TIME_W-1:0] alu_a, alu_b, alu_y;
    logic              alu_sub;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign lvl         = level_reg[btn_reg];
    assign cur_raw     = raw_reg[btn_reg];
    assign cur_stable  = stable_reg[btn_reg];
    assign cur_blocked = blocked_reg[btn_reg];
    assign cur_en      = enable_reg[btn_reg];
    assign cur_rp      = repeat_reg[btn_reg];
    assign ct_new      = (lvl != cur_raw) ? now_reg : ct_reg[btn_reg];
    assign cur_code    = events_reg[{btn_reg, 3'b000} +: EVENT_BITS];
    assign shifted     = {rem_reg, dq_reg[TIME_W-2]};

    // operand select for the shared add/subtract unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                alu_a = now_reg;
                alu_b = TIME_W'(delay_reg);
            end
            ST_RAW:
            begin
                alu_a = ct_new;
                alu_b = TIME_W'(debounce_reg);
            end
            ST_DEB:
            begin
                alu_a   = now_reg;
                alu_b   = tmp_reg;
                alu_sub = 1'b1;
            end
            ST_ARM:
            begin
                alu_a = now_reg;
                alu_b = TIME_W'(delay_reg);
            end
            ST_RPT:
            begin
                alu_a   = now_reg;
                alu_b   = nrt_reg[btn_reg];
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = TIME_W'(shifted);
                alu_b   = TIME_W'(interval_reg);
                alu_sub = 1'b1;
            end
            ST_ADV1:
            begin
                alu_a = now_reg;
                alu_b = TIME_W'(interval_reg);
            end
            ST_ADV2:
            begin
                alu_a   = tmp_reg;
                alu_b   = TIME_W'(rem_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);

    // debounce time reached on a pending level change
    assign deb_hit = (cur_stable != cur_raw) && !alu_y[TIME_W-1];

    // next state and strobes
    always_comb
    begin
        state_next      = state_reg;
        btn_next        = btn_reg;
        ready_next      = ready_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_load_last   = 1'b0;
        pend_load       = 1'b0;
        go_next         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == CMD_INIT)
                    begin
                        state_next = ST_INIT;
                    end
                    else if (command == CMD_UPDATE && ready_reg)
                    begin
                        btn_next   = '0;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_INIT:
            begin
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RAW:
            begin
                state_next = ST_DEB;
            end
            ST_DEB:
            begin
                if (deb_hit)
                begin
                    if (cur_raw)
                        state_next = ST_ARM;
                    else
                        go_next = 1'b1;
                end
                else if (cur_stable && !cur_blocked && cur_en && cur_rp &&
                         interval_reg != '0)
                begin
                    state_next = ST_RPT;
                end
                else
                begin
                    go_next = 1'b1;
                end
            end
            ST_ARM:
            begin
                if (cur_en)
                    state_next = ST_FIRE;
                else
                    go_next = 1'b1;
            end
            ST_RPT:
            begin
                if (alu_y[TIME_W-1])
                    go_next = 1'b1;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = ST_ADV1;
            end
            ST_ADV1:
            begin
                state_next = ST_ADV2;
            end
            ST_ADV2:
            begin
                state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                // hold one event back so the final one can carry last
                if (!pend_valid_reg)
                begin
                    pend_load = 1'b1;
                    go_next   = 1'b1;
                end
                else if (out_free)
                begin
                    out_load  = 1'b1;
                    pend_load = 1'b1;
                    go_next   = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_load_last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pend_load)
            pend_valid_next = 1'b1;

        // advance to the next button or finish
        if (go_next)
        begin
            if (btn_reg == BTN_W'(NUM_BUTTONS - 1))
            begin
                state_next = ST_FLUSH;
            end
            else
            begin
                btn_next   = btn_reg + 1'b1;
                state_next = ST_RAW;
            end
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            btn_reg        <= '0;
            ready_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            btn_reg        <= btn_next;
            ready_reg      <= ready_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
            enable_reg   <= '0;
            repeat_reg   <= '0;
            events_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[MS_W-1:0];
                REG_DELAY:    delay_reg    <= cfg_data[MS_W-1:0];
                REG_INTERVAL: interval_reg <= cfg_data[MS_W-1:0];
                REG_ENABLE:   enable_reg   <= cfg_data[MASK_W-1:0];
                REG_REPEAT:   repeat_reg   <= cfg_data[MASK_W-1:0];
                REG_EVENTS:   events_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // level flags per button
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg     <= '0;
            stable_reg  <= '0;
            blocked_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && command == CMD_MAP)
                        blocked_reg <= blocked_reg | stable_reg;
                end
                ST_INIT:
                begin
                    raw_reg     <= level_reg;
                    stable_reg  <= level_reg;
                    blocked_reg <= level_reg;
                end
                ST_RAW:
                begin
                    raw_reg[btn_reg] <= lvl;
                end
                ST_DEB:
                begin
                    if (deb_hit)
                    begin
                        stable_reg[btn_reg]  <= cur_raw;
                        blocked_reg[btn_reg] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // timestamps and shared unit scratch
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    level_reg <= level_mask[NUM_BUTTONS-1:0];
                    now_reg   <= time_ms;
                end
            end
            ST_INIT:
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    ct_reg[i]  <= now_reg;
                    nrt_reg[i] <= alu_y;
                end
            end
            ST_RAW:
            begin
                ct_reg[btn_reg] <= ct_new;
                tmp_reg         <= alu_y;
            end
            ST_ARM:
            begin
                nrt_reg[btn_reg] <= alu_y;
            end
            ST_RPT:
            begin
                dq_reg      <= alu_y[TIME_W-2:0];
                rem_reg     <= '0;
                div_cnt_reg <= 5'(TIME_W - 2);
            end
            ST_DIV:
            begin
                // one restoring remainder step per cycle
                rem_reg     <= alu_y[TIME_W-1] ? shifted[MS_W-1:0] : alu_y[MS_W-1:0];
                dq_reg      <= {dq_reg[TIME_W-3:0], 1'b0};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            ST_ADV1:
            begin
                tmp_reg <= alu_y;
            end
            ST_ADV2:
            begin
                nrt_reg[btn_reg] <= alu_y;
            end
            default:
            begin
            end
        endcase
    end

    // pending and output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= pend_idx_reg;
            out_code_reg <= pend_code_reg;
            out_last_reg <= out_load_last;
        end
        if (pend_load)
        begin
            pend_idx_reg  <= btn_reg;
            pend_code_reg <= cur_code;
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_index = IDX_W'(out_idx_reg);
    assign event_code   = out_code_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/bda_checker.sv */
// ---------------------------------------------------------------------------
// bda_checker
// Port-level assertions for the debounce / auto-repeat block, bound to the
// top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_autorepeat_defines.svh"

module bda_checker
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int EVENT_BITS  = EVENT_BITS_DEF
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic [CMD_W-1:0]      command,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [IDX_W-1:0]      button_index,
    input wire logic [EVENT_BITS-1:0] event_code,
    input wire logic                  last
);

    // stalled output beat holds
    `BDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(button_index) && $stable(event_code) && $stable(last),
        "output beat changed while stalled")

    // init always raises in_stall after it is accepted
    `BDA_ASSERT_NEXT(a_init_busy, in_valid && !in_stall && command == CMD_INIT,
        in_stall, "init beat not followed by busy cycle")

    // events are only produced while an update is being worked on
    `BDA_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall),
        "output beat appeared without work in progress")

    // button index stays inside the configured count
    `BDA_ASSERT_NOW(a_idx_range, out_valid, button_index <= IDX_W'(NUM_BUTTONS - 1),
        "button index out of range")

endmodule

bind button_debounce_autorepeat bda_checker #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .EVENT_BITS  (EVENT_BITS)
) u_bda_checker (.*);

`default_nettype wire
